// ===== src/switched_load_energy_meter_top_assert.svh =====
// assertion macros used by the energy meter top
`ifndef SWITCHED_LOAD_ENERGY_METER_TOP_ASSERT_SVH
`define SWITCHED_LOAD_ENERGY_METER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SLEM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slem_pkg.sv =====
// ----------------------------------------------------------------------------
// slem_pkg
// Types, codes and constants of the switched load energy meter.
// ----------------------------------------------------------------------------
package slem_pkg;

  // fixed field and datapath widths
  localparam int unsigned SUM_W        = 32;
  localparam int unsigned DIVIDEND_W   = 32;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned PROD_W       = 48;
  localparam int unsigned OUT_ENERGY_W = 48;
  localparam int unsigned RUN_W        = 5;
  localparam int unsigned TICK_W       = 6;
  localparam int unsigned THRESH_W     = 15;
  localparam int unsigned CONFIRM_W    = 4;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 2;

  // register reset values and the run length limit
  localparam logic [THRESH_W-1:0]  THRESH_RST  = 15'd10;
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST = 4'd5;
  localparam logic [GAIN_W-1:0]    GAIN_RST    = 16'd3666;
  localparam logic [TICK_W-1:0]    PERIOD_RST  = 6'd60;
  localparam logic [RUN_W-1:0]     RUN_MAX     = '1;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_COMMAND = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_ON           = 3'd0,
    CMD_OFF          = 3'd1,
    CMD_TELEM_ON     = 3'd2,
    CMD_RESET        = 3'd3,
    CMD_READ_CURRENT = 3'd4,
    CMD_READ_ENERGY  = 3'd5,
    CMD_READ_STATE   = 3'd6,
    CMD_CLEAR_ENERGY = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    RK_NONE      = 3'd0,
    RK_ACK       = 3'd1,
    RK_CURRENT   = 3'd2,
    RK_ENERGY    = 3'd3,
    RK_STATE     = 3'd4,
    RK_TELEMETRY = 3'd5
  } reply_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH  = 2'd0,
    CFG_CONFIRM = 2'd1,
    CFG_GAIN    = 2'd2,
    CFG_PERIOD  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_ma;
    logic [2:0]         command_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                  reply_kind;
    logic                        relay_drive;
    logic                        load_present;
    logic signed [15:0]          reported_current_ma;
    logic [OUT_ENERGY_W-1:0]     reported_energy;
  } out_item_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/slem_div.sv =====
// ----------------------------------------------------------------------------
// slem_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slem_div import slem_pkg::*; #(
  parameter int unsigned DIVISOR_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output div_status_t           status_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;
  logic                  last;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
    fits    = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
    last    = cnt_q == CNT_W'(DIVIDEND_W - 1);
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

// ===== src/switched_load_energy_meter_top.sv =====
// An item that ends no period, or ends an empty one, passes from the idle state through
// CHECK to DONE, where its result is registered; a period end with samples runs the
// divider in DIV and then MUL and ACC between CHECK and DONE.
// A new item is taken only in the idle state, after the last one's result is registered.
// A waiting result holds the next item in its last step until the result is taken.
// Reset (rst_ni low, asynchronous) clears meter state registers and loads register defaults.
// ----------------------------------------------------------------------------
// switched_load_energy_meter_top
// Relay control and energy metering over a stream of samples, ticks and
// commands, with a divider for the period average.
// ----------------------------------------------------------------------------
`include "switched_load_energy_meter_top_assert.svh"

module switched_load_energy_meter_top import slem_pkg::*; #(
  parameter int unsigned MAX_PERIOD_SAMPLES = 65535,
  parameter int unsigned ENERGY_BITS        = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_PERIOD_SAMPLES + 1);
  localparam int unsigned ACC_W = ((ENERGY_BITS > PROD_W) ? ENERGY_BITS : PROD_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PERIOD_SAMPLES);
  localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;

  // configuration registers
  logic [THRESH_W-1:0]  thresh_q;
  logic [CONFIRM_W-1:0] confirm_q;
  logic [GAIN_W-1:0]    gain_q;
  logic [TICK_W-1:0]    period_q;

  // meter state
  state_e                 st_q, st_d;
  logic                   relay_q, relay_d;
  logic                   telem_q, telem_d;
  logic                   load_q, load_d;
  logic [RUN_W-1:0]       run_q, run_d;
  logic signed [15:0]     last_q, last_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TICK_W-1:0]      tick_q, tick_d;
  logic [ENERGY_BITS-1:0] energy_q, energy_d;
  reply_kind_e            reply_q, reply_d;
  logic                   neg_q, neg_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  // working signals
  logic                    in_fire;
  logic                    div_start;
  div_status_t             div_st;
  logic [DIVIDEND_W-1:0]   div_quot;
  logic [DIVIDEND_W-1:0]   sum_mag;
  logic signed [SUM_W:0]   sum_ext;
  logic                    above;
  logic                    due;
  logic [ACC_W-1:0]        acc_add;
  logic [ACC_W-1:0]        acc_sub;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = st_q == ST_IDLE;

  // period divider
  slem_div #(
    .DIVISOR_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .status_o   (div_st),
    .quotient_o (div_quot)
  );

  // sample arithmetic
  always_comb begin
    sum_ext = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(in_item_i.sample_ma);
    above   = in_item_i.sample_ma > $signed({1'b0, thresh_q});
    sum_mag = sum_q[SUM_W-1] ? DIVIDEND_W'(~sum_q + 1'b1) : DIVIDEND_W'(sum_q);
    due     = tick_q >= period_q;
    acc_add = ACC_W'(energy_q) + ACC_W'(prod_q);
    acc_sub = ACC_W'(energy_q) - ACC_W'(prod_q);
  end

  // sequencer: next state and datapath updates
  always_comb begin
    st_d        = st_q;
    relay_d     = relay_q;
    telem_d     = telem_q;
    load_d      = load_q;
    run_d       = run_q;
    last_d      = last_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    energy_d    = energy_q;
    reply_d     = reply_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          st_d    = ST_CHECK;
          reply_d = RK_NONE;
          unique case (kind_e'(in_item_i.kind))
            KIND_SAMPLE: begin
              last_d  = in_item_i.sample_ma;
              reply_d = telem_q ? RK_TELEMETRY : RK_NONE;
              if (relay_q) begin
                // saturating sum and count
                if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                  sum_d = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
                end else begin
                  sum_d = sum_ext[SUM_W-1:0];
                end
                if (cnt_q < CNT_MAX) begin
                  cnt_d = cnt_q + 1'b1;
                end
                // load run tracking
                if (above) begin
                  if (run_q != RUN_MAX) begin
                    run_d = run_q + 1'b1;
                  end
                  if (run_q > {1'b0, confirm_q}) begin
                    load_d = 1'b1;
                  end
                end else begin
                  run_d  = '0;
                  load_d = 1'b0;
                end
              end
            end
            KIND_TICK: begin
              tick_d = tick_q + 1'b1;
            end
            KIND_COMMAND: begin
              reply_d = RK_ACK;
              unique case (cmd_e'(in_item_i.command_code))
                CMD_ON:           relay_d = 1'b1;
                CMD_OFF:          relay_d = 1'b0;
                CMD_TELEM_ON:     telem_d = 1'b1;
                CMD_RESET: begin
                  tick_d   = '0;
                  last_d   = '0;
                  sum_d    = '0;
                  cnt_d    = '0;
                  energy_d = '0;
                end
                CMD_READ_CURRENT: reply_d = RK_CURRENT;
                CMD_READ_ENERGY:  reply_d = RK_ENERGY;
                CMD_READ_STATE:   reply_d = RK_STATE;
                CMD_CLEAR_ENERGY: energy_d = '0;
              endcase
            end
            KIND_UNUSED: ;
          endcase
        end
      end
      ST_CHECK: begin
        st_d = ST_DONE;
        if (due) begin
          tick_d = '0;
          sum_d  = '0;
          cnt_d  = '0;
          neg_d  = sum_q[SUM_W-1];
          // an empty period adds nothing
          if (cnt_q != '0) begin
            div_start = 1'b1;
            st_d      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(div_quot) * PROD_W'(gain_q);
        st_d   = ST_ACC;
      end
      ST_ACC: begin
        // saturating accumulate
        if (!neg_q) begin
          energy_d = (acc_add > ACC_W'(ENERGY_MAX)) ? ENERGY_MAX
                                                    : acc_add[ENERGY_BITS-1:0];
        end else begin
          energy_d = (ACC_W'(prod_q) > ACC_W'(energy_q)) ? '0
                                                         : acc_sub[ENERGY_BITS-1:0];
        end
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_d.reply_kind           = reply_q;
          out_d.relay_drive          = relay_q;
          out_d.load_present         = load_q;
          out_d.reported_current_ma  = last_q;
          out_d.reported_energy      = OUT_ENERGY_W'(ACC_W'(energy_q));
          st_d                       = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // meter state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q     <= 1'b0;
      telem_q     <= 1'b0;
      load_q      <= 1'b0;
      run_q       <= '0;
      last_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      tick_q      <= '0;
      energy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      relay_q     <= relay_d;
      telem_q     <= telem_d;
      load_q      <= load_d;
      run_q       <= run_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      energy_q    <= energy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= THRESH_RST;
      confirm_q <= CONFIRM_RST;
      gain_q    <= GAIN_RST;
      period_q  <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESH:  thresh_q  <= cfg_wdata_i[THRESH_W-1:0];
        CFG_CONFIRM: confirm_q <= cfg_wdata_i[CONFIRM_W-1:0];
        CFG_GAIN:    gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_PERIOD:  period_q  <= cfg_wdata_i[TICK_W-1:0];
      endcase
    end
  end

  // per-item scratch and output payload
  always_ff @(posedge clk_i) begin
    reply_q <= reply_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks on the sequencer and the divider handoff
  `SLEM_ASSERT_NXT(a_accept_to_check, clk_i, rst_ni, in_fire,
                   (st_q == ST_CHECK) && !in_ready_o, "item accept did not enter check")
  `SLEM_ASSERT_IMP(a_div_nonzero, clk_i, rst_ni, div_start, cnt_q != '0,
                   "divider started with zero sample count")
  `SLEM_ASSERT_NXT(a_div_to_mul, clk_i, rst_ni, (st_q == ST_DIV) && div_st.done,
                   st_q == ST_MUL, "divider result not taken")
  `SLEM_ASSERT_IMP(a_idle_div_quiet, clk_i, rst_ni, st_q == ST_IDLE, !div_st.busy,
                   "divider busy while no item in progress")

endmodule
